FILE: design/cdbq_pkg.sv
// ----------------------------------------------------------------------------
// cdbq_pkg
// Shared types and constants of the column degree bucket queue.
// ----------------------------------------------------------------------------
package cdbq_pkg;

    // widths of the request and result fields
    localparam int COL_W = 6;
    localparam int DEG_W = 7;

    // configuration registers
    localparam int REG_W     = 7;
    localparam int REG_MAX   = 2 ** REG_W - 1;
    localparam int REG_RST   = 64;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // lowest-degree tracker, wide enough for the top bucket plus one
    localparam int LOW_W = REG_W + 1;

    // register index, taken from the word address
    localparam logic REG_MAX_DEG  = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // request commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // configuration seen by the queue engine
    typedef struct packed {
        logic [REG_W-1:0] max_deg;
        logic [REG_W-1:0] num_cols;
        logic             clr;
    } t_cfg;

endpackage

FILE: design/cdbq_if.sv
// ----------------------------------------------------------------------------
// cdbq_if
// Valid/ready channels of the queue: request in, pop result out.
// ----------------------------------------------------------------------------
interface cdbq_in_if import cdbq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [COL_W-1:0] col;
    logic [DEG_W-1:0] degree;

    modport source (output valid, output cmd, output col, output degree, input ready);
    modport sink   (input valid, input cmd, input col, input degree, output ready);
endinterface

interface cdbq_out_if import cdbq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] popped_col;
    logic             found;

    modport source (output valid, output popped_col, output found, input ready);
    modport sink   (input valid, input popped_col, input found, output ready);
endinterface

FILE: design/cdbq_cfg.sv
// ----------------------------------------------------------------------------
// cdbq_cfg
// APB register file: top bucket and column count, with a clear pulse on
// every write.
// ----------------------------------------------------------------------------
module cdbq_cfg import cdbq_pkg::*; #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_DEGREE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic [REG_W-1:0] DEG_CAP  = REG_W'((MAX_DEGREE < REG_MAX) ? MAX_DEGREE : REG_MAX);
    localparam logic [REG_W-1:0] COLS_CAP = REG_W'((MAX_COLS < REG_MAX) ? MAX_COLS : REG_MAX);
    localparam logic [REG_W-1:0] DEG_RST  = REG_W'((REG_RST < MAX_DEGREE) ? REG_RST : MAX_DEGREE);
    localparam logic [REG_W-1:0] COLS_RST = REG_W'((REG_RST < MAX_COLS) ? REG_RST : MAX_COLS);

    logic [REG_W-1:0] r_max_deg;
    logic [REG_W-1:0] r_num_cols;
    logic             r_clr;
    logic             wr_en;
    logic [REG_W-1:0] wdat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wdat   = pwdata[REG_W-1:0];

    // register writes, saturated to the built-in sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_deg  <= DEG_RST;
            r_num_cols <= COLS_RST;
            r_clr      <= 1'b0;
        end else begin
            r_clr <= wr_en;
            if (wr_en) begin
                unique case (paddr[2])
                    REG_MAX_DEG:  r_max_deg  <= (wdat > DEG_CAP) ? DEG_CAP : wdat;
                    REG_NUM_COLS: r_num_cols <= (wdat > COLS_CAP) ? COLS_CAP : wdat;
                endcase
            end
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_MAX_DEG:  prdata = APB_DW'(r_max_deg);
            REG_NUM_COLS: prdata = APB_DW'(r_num_cols);
        endcase
    end

    assign o_cfg.max_deg  = r_max_deg;
    assign o_cfg.num_cols = r_num_cols;
    assign o_cfg.clr      = r_clr;

endmodule

FILE: design/cdbq_core.sv
// ----------------------------------------------------------------------------
// cdbq_core
// Queue engine: column/fill table and bucket entry memory, walked by a
// read-modify-write sequencer; queued and non-empty flags in flops.
// ----------------------------------------------------------------------------
module cdbq_core import cdbq_pkg::*; #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_DEGREE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    cdbq_in_if.sink     i_req,
    cdbq_out_if.source  o_rsp
);

    localparam int NB  = MAX_DEGREE + 1;
    localparam int CW  = $clog2(MAX_COLS);
    localparam int BW  = $clog2(NB);
    localparam int FW  = $clog2(MAX_COLS + 1);
    localparam int TW  = BW + CW;
    localparam int TD  = MAX_COLS + NB;
    localparam int TAW = $clog2(TD);
    localparam int ED  = NB * MAX_COLS;
    localparam int EAW = $clog2(ED);
    localparam logic [LOW_W-1:0] LOW_RST = LOW_W'((REG_RST < MAX_COLS) ? REG_RST : MAX_COLS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_COL,
        S_P_OFILL,
        S_P_LAST,
        S_N_FILL,
        S_N_COL,
        S_SCAN,
        S_POP_FILL,
        S_POP_ENT,
        S_POP_OUT
    } t_state;

    // table: column entries {degree, slot} below MAX_COLS, bucket fills above
    function automatic logic [TAW-1:0] col_addr(input logic [CW-1:0] c);
        return TAW'(c);
    endfunction

    function automatic logic [TAW-1:0] bkt_addr(input logic [BW-1:0] b);
        return TAW'(MAX_COLS) + TAW'(b);
    endfunction

    function automatic logic [EAW-1:0] ent_addr(input logic [BW-1:0] b,
                                                input logic [CW-1:0] s);
        return EAW'(b) * EAW'(MAX_COLS) + EAW'(s);
    endfunction

    logic [TW-1:0]    r_tbl_mem [TD];
    logic [CW-1:0]    r_ent_mem [ED];
    logic [TW-1:0]    r_tbl_rd;
    logic [CW-1:0]    r_ent_rd;

    t_state           r_state;
    logic [CW-1:0]    r_col;
    logic [BW-1:0]    r_deg;
    logic [BW-1:0]    r_old;
    logic [CW-1:0]    r_slot;
    logic [LOW_W-1:0] r_d;
    logic [LOW_W-1:0] r_low;
    logic [MAX_COLS-1:0] r_q;
    logic [NB-1:0]    r_ne;
    logic [CW-1:0]    r_pop_col;
    logic             r_pop_found;
    logic             r_o_vld;
    logic [COL_W-1:0] r_o_col;
    logic             r_o_found;

    logic [BW-1:0]    rd_deg;
    logic [CW-1:0]    rd_slot;
    logic [FW-1:0]    rd_fill;
    logic [BW-1:0]    old_deg;
    logic [FW-1:0]    fill_new;
    logic [FW-1:0]    top;
    logic [LOW_W-1:0] max_low;
    logic             req_acc;
    logic             push_ok;

    logic [TAW-1:0]   tbl_ra;
    logic             tbl_we;
    logic [TAW-1:0]   tbl_wa;
    logic [TW-1:0]    tbl_wd;
    logic [EAW-1:0]   ent_ra;
    logic             ent_we;
    logic [EAW-1:0]   ent_wa;
    logic [CW-1:0]    ent_wd;

    // handshake
    assign i_req.ready      = (r_state == S_IDLE) && !i_cfg.clr;
    assign req_acc          = i_req.valid && i_req.ready;
    assign push_ok          = (REG_W'(i_req.col) < i_cfg.num_cols)
                              && (i_req.degree <= i_cfg.max_deg);
    assign o_rsp.valid      = r_o_vld;
    assign o_rsp.popped_col = r_o_col;
    assign o_rsp.found      = r_o_found;
    assign max_low          = LOW_W'(i_cfg.max_deg);

    // memories, registered read data
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= tbl_wd;
        end
        r_tbl_rd <= r_tbl_mem[tbl_ra];
        if (ent_we) begin
            r_ent_mem[ent_wa] <= ent_wd;
        end
        r_ent_rd <= r_ent_mem[ent_ra];
    end

    // decode of read data and memory port control
    always_comb begin
        rd_deg   = r_tbl_rd[TW-1:CW];
        rd_slot  = r_tbl_rd[CW-1:0];
        rd_fill  = r_tbl_rd[FW-1:0];
        old_deg  = r_q[r_col] ? rd_deg : '0;
        fill_new = r_ne[r_deg] ? rd_fill : '0;
        top      = rd_fill - FW'(1);

        tbl_ra = col_addr(CW'(i_req.col));
        tbl_we = 1'b0;
        tbl_wa = '0;
        tbl_wd = '0;
        ent_ra = '0;
        ent_we = 1'b0;
        ent_wa = '0;
        ent_wd = '0;

        unique case (r_state)
            S_P_COL: begin
                tbl_ra = bkt_addr(r_q[r_col] ? old_deg : r_deg);
            end
            S_P_OFILL: begin
                // shrink the old bucket, fetch its top column
                ent_ra = ent_addr(r_old, CW'(top));
                tbl_we = 1'b1;
                tbl_wa = bkt_addr(r_old);
                tbl_wd = TW'(top);
            end
            S_P_LAST: begin
                // move the top column into the hole
                ent_we = 1'b1;
                ent_wa = ent_addr(r_old, r_slot);
                ent_wd = r_ent_rd;
                tbl_we = 1'b1;
                tbl_wa = col_addr(r_ent_rd);
                tbl_wd = {r_old, r_slot};
                tbl_ra = bkt_addr(r_deg);
            end
            S_N_FILL: begin
                // append to the new bucket
                tbl_we = 1'b1;
                tbl_wa = bkt_addr(r_deg);
                tbl_wd = TW'(fill_new + FW'(1));
                ent_we = 1'b1;
                ent_wa = ent_addr(r_deg, CW'(fill_new));
                ent_wd = r_col;
            end
            S_N_COL: begin
                tbl_we = 1'b1;
                tbl_wa = col_addr(r_col);
                tbl_wd = {r_deg, r_slot};
            end
            S_SCAN: begin
                tbl_ra = bkt_addr(BW'(r_d));
            end
            S_POP_FILL: begin
                tbl_we = 1'b1;
                tbl_wa = bkt_addr(r_deg);
                tbl_wd = TW'(top);
                ent_ra = ent_addr(r_deg, CW'(top));
            end
            default: ;
        endcase
    end

    // sequencer, flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= '0;
            r_ne    <= '0;
            r_low   <= LOW_RST;
            r_o_vld <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
            if (i_cfg.clr) begin
                r_q   <= '0;
                r_ne  <= '0;
                r_low <= LOW_W'(i_cfg.num_cols);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        if (i_req.cmd == CMD_POP) begin
                            r_d     <= r_low;
                            r_state <= S_SCAN;
                        end else if (push_ok) begin
                            r_col   <= CW'(i_req.col);
                            r_deg   <= BW'(i_req.degree);
                            r_state <= S_P_COL;
                        end
                    end
                end
                S_P_COL: begin
                    r_old  <= old_deg;
                    r_slot <= rd_slot;
                    if (r_deg == old_deg) begin
                        r_state <= S_IDLE;
                    end else if (r_q[r_col]) begin
                        r_state <= S_P_OFILL;
                    end else begin
                        r_state <= S_N_FILL;
                    end
                end
                S_P_OFILL: begin
                    r_ne[r_old] <= (top != '0);
                    r_state     <= S_P_LAST;
                end
                S_P_LAST: begin
                    if (r_deg != '0) begin
                        r_state <= S_N_FILL;
                    end else begin
                        r_q[r_col] <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_N_FILL: begin
                    r_slot      <= CW'(fill_new);
                    r_ne[r_deg] <= 1'b1;
                    if (LOW_W'(r_deg) < r_low) begin
                        r_low <= LOW_W'(r_deg);
                    end
                    r_state <= S_N_COL;
                end
                S_N_COL: begin
                    r_q[r_col] <= 1'b1;
                    r_state    <= S_IDLE;
                end
                S_SCAN: begin
                    // one bucket per cycle from the running minimum
                    if (r_d > max_low) begin
                        if (r_low <= max_low) begin
                            r_low <= max_low + LOW_W'(1);
                        end
                        r_pop_found <= 1'b0;
                        r_pop_col   <= '0;
                        r_state     <= S_POP_OUT;
                    end else if (r_ne[BW'(r_d)]) begin
                        r_low   <= r_d;
                        r_deg   <= BW'(r_d);
                        r_state <= S_POP_FILL;
                    end else begin
                        r_d <= r_d + LOW_W'(1);
                    end
                end
                S_POP_FILL: begin
                    r_ne[r_deg] <= (top != '0);
                    r_state     <= S_POP_ENT;
                end
                S_POP_ENT: begin
                    r_q[r_ent_rd] <= 1'b0;
                    r_pop_col     <= r_ent_rd;
                    r_pop_found   <= 1'b1;
                    r_state       <= S_POP_OUT;
                end
                S_POP_OUT: begin
                    if (!r_o_vld || o_rsp.ready) begin
                        r_o_vld   <= 1'b1;
                        r_o_col   <= COL_W'(r_pop_col);
                        r_o_found <= r_pop_found;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/column_degree_bucket_queue_unit.sv
// ----------------------------------------------------------------------------
// column_degree_bucket_queue_unit
// Push: runs the read-modify-write states before the next request is taken;
// an unchanged degree ends after the column lookup, an out-of-range column
// or degree is dropped. Pop: skips empty buckets above the running minimum;
// the scan checks one bucket a cycle and each memory has a single read port.
// Reset: queue empty, both registers 64 (saturated), no clearing pass.
// ----------------------------------------------------------------------------
module column_degree_bucket_queue_unit import cdbq_pkg::*; #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_DEGREE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdbq_in_if.sink           i_req,
    cdbq_out_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;

    // register file
    cdbq_cfg #(
        .MAX_COLS   (MAX_COLS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // queue engine
    cdbq_core #(
        .MAX_COLS   (MAX_COLS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: design/cdbq_chk.sv
// ----------------------------------------------------------------------------
// cdbq_chk
// Port-level checks of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module cdbq_chk import cdbq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_cmd,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [COL_W-1:0] i_out_col,
    input logic             i_out_found,
    input logic             i_cfg_wr
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_col)
            && $stable(i_out_found))
        else $error("stalled result changed");

    // an empty pop reports column zero
    a_empty_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_col == '0)
        else $error("empty pop with nonzero column");

    // a push never produces a result
    a_push_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_PUSH) && !i_out_valid
            |=> !i_out_valid)
        else $error("result after a push");

    // the clear that follows a register write holds off requests
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> !i_in_ready)
        else $error("request taken during clear");

    // no result straight out of reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind column_degree_bucket_queue_unit cdbq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_cmd    (i_req.cmd),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_col   (o_rsp.popped_col),
    .i_out_found (o_rsp.found),
    .i_cfg_wr    (psel && penable && pwrite)
);
